### src/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and helpers for the base64 decoder
// Character classes and the alphabet lookup used by the decode datapath.
// ----------------------------------------------------------------------------
package b64d_pkg;

    // widths of the decoder state
    localparam int unsigned ACC_W   = 18;
    localparam int unsigned GROUP_W = 24;

    // input item modes
    localparam logic MODE_CHAR   = 1'b0;
    localparam logic MODE_FINISH = 1'b1;

    // pad counts that select a flush at finish
    localparam logic [1:0] PAD_ONE = 2'd1;
    localparam logic [1:0] PAD_TWO = 2'd2;

    // class of one input character
    typedef enum logic [2:0] {
        CLS_DATA  = 3'd0,
        CLS_NUL   = 3'd1,
        CLS_BLANK = 3'd2,
        CLS_PAD   = 3'd3,
        CLS_BAD   = 3'd4
    } char_kind_t;

    typedef struct packed {
        char_kind_t  kind;
        logic [5:0]  value;
    } char_class_t;

    // standard alphabet lookup, value is zero unless kind is data
    function automatic char_class_t classify(input logic [7:0] ch);
        char_class_t res;
        res.kind  = CLS_BAD;
        res.value = 6'd0;
        case (ch) inside
            8'h00:
                res.kind = CLS_NUL;
            [8'h01:8'h20]:
                res.kind = CLS_BLANK;
            [8'h41:8'h5a]:
            begin
                res.kind  = CLS_DATA;
                res.value = 6'(ch - 8'h41);
            end
            [8'h61:8'h7a]:
            begin
                res.kind  = CLS_DATA;
                res.value = 6'(ch - 8'h61 + 8'd26);
            end
            [8'h30:8'h39]:
            begin
                res.kind  = CLS_DATA;
                res.value = 6'(ch - 8'h30 + 8'd52);
            end
            8'h2b:
            begin
                res.kind  = CLS_DATA;
                res.value = 6'd62;
            end
            8'h2f:
            begin
                res.kind  = CLS_DATA;
                res.value = 6'd63;
            end
            8'h3d:
                res.kind = CLS_PAD;
            default:
                res.kind = CLS_BAD;
        endcase
        return res;
    endfunction

endpackage

### src/base64_decoder_unit.sv
// ----------------------------------------------------------------------------
// base64_decoder_unit: streaming base64 decoder
// Takes one character or one finish request per transfer and returns one to
// three results: decoded bytes, or a single status result.
// ----------------------------------------------------------------------------
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  input   | in_valid/in_ready, mode, text_char,       | in
//          | chunk_end                                |
//  output  | out_valid/out_ready, data_byte,           | out
//          | byte_valid, status, last                 |
//
//  An accepted item is held in the input register, then is decoded in
//  a single pass into the result buffer (up to three results).
//  Throughput is one item per cycle while out_ready is high and each item
//  gives one result; an item that completes a group holds the buffer for
//  three output transfers, a one-pad finish for two.
//  While results wait on out_ready the input register holds one more item
//  and in_ready drops until the buffer can take it.
//  Reset (rst_n low, asynchronous) clears decoder state and both stages.
// ----------------------------------------------------------------------------
module base64_decoder_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       mode,
    input  logic [7:0] text_char,
    input  logic       chunk_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] data_byte,
    output logic       byte_valid,
    output logic       status,
    output logic       last
);

    // input register
    logic       item_valid_reg;
    logic       mode_reg;
    logic [7:0] char_reg;
    logic       cend_reg;

    // decoder state
    logic [b64d_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [1:0] group_cnt_reg, group_cnt_next;
    logic [1:0] pad_cnt_reg, pad_cnt_next;
    logic       err_reg, err_next;
    logic       skip_reg, skip_next;

    // result buffer
    logic [7:0] byte0_reg, byte1_reg, byte2_reg;
    logic [1:0] num_reg;
    logic       bvalid_reg;
    logic       status_reg;

    // decoded results of the item in the input register
    logic [7:0] res_b0, res_b1, res_b2;
    logic [1:0] res_num;
    logic       res_bvalid;
    logic       res_status;

    logic                          load;
    logic                          out_xfer;
    b64d_pkg::char_class_t         cls;
    logic [b64d_pkg::GROUP_W-1:0]  group_word;
    logic                          fin_bad;

    // handshake
    assign out_xfer = out_valid && out_ready;
    assign load     = item_valid_reg && ((num_reg == 2'd0) || ((num_reg == 2'd1) && out_ready));
    assign in_ready = !item_valid_reg || load;

    assign cls        = b64d_pkg::classify(char_reg);
    assign group_word = {acc_reg, cls.value};
    assign fin_bad    = err_reg || ((group_cnt_reg + pad_cnt_reg) != 2'd0);

    // decode one item
    always_comb
    begin
        acc_next       = acc_reg;
        group_cnt_next = group_cnt_reg;
        pad_cnt_next   = pad_cnt_reg;
        err_next       = err_reg;
        skip_next      = skip_reg;
        res_b0         = 8'd0;
        res_b1         = 8'd0;
        res_b2         = 8'd0;
        res_num        = 2'd1;
        res_bvalid     = 1'b0;
        res_status     = 1'b0;
        if (mode_reg == b64d_pkg::MODE_FINISH)
        begin
            // flush partial group and clear everything
            res_status = fin_bad;
            if (!fin_bad && (pad_cnt_reg == b64d_pkg::PAD_TWO))
            begin
                res_b0     = acc_reg[11:4];
                res_bvalid = 1'b1;
            end
            else if (!fin_bad && (pad_cnt_reg == b64d_pkg::PAD_ONE))
            begin
                res_b0     = acc_reg[17:10];
                res_b1     = acc_reg[9:2];
                res_num    = 2'd2;
                res_bvalid = 1'b1;
            end
            acc_next       = '0;
            group_cnt_next = 2'd0;
            pad_cnt_next   = 2'd0;
            err_next       = 1'b0;
            skip_next      = 1'b0;
        end
        else
        begin
            if (skip_reg)
            begin
                if (cend_reg)
                    skip_next = 1'b0;
            end
            else if (!err_reg)
            begin
                case (cls.kind)
                    b64d_pkg::CLS_NUL:
                    begin
                        if (!cend_reg)
                            skip_next = 1'b1;
                    end
                    b64d_pkg::CLS_BLANK:
                    begin
                        skip_next = skip_reg;
                    end
                    b64d_pkg::CLS_PAD:
                    begin
                        if (pad_cnt_reg == b64d_pkg::PAD_TWO)
                            err_next = 1'b1;
                        else
                            pad_cnt_next = pad_cnt_reg + 2'd1;
                    end
                    b64d_pkg::CLS_DATA:
                    begin
                        if (pad_cnt_reg != 2'd0)
                            err_next = 1'b1;
                        else if (group_cnt_reg == 2'd3)
                        begin
                            // group complete: three bytes, high first
                            res_b0         = group_word[23:16];
                            res_b1         = group_word[15:8];
                            res_b2         = group_word[7:0];
                            res_num        = 2'd3;
                            res_bvalid     = 1'b1;
                            acc_next       = '0;
                            group_cnt_next = 2'd0;
                        end
                        else
                        begin
                            acc_next       = group_word[b64d_pkg::ACC_W-1:0];
                            group_cnt_next = group_cnt_reg + 2'd1;
                        end
                    end
                    default:
                        err_next = 1'b1;
                endcase
            end
            res_status = res_bvalid ? 1'b0 : err_next;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ready)
            item_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg <= mode;
            char_reg <= text_char;
            cend_reg <= chunk_end;
        end
    end

    // decoder state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            group_cnt_reg <= 2'd0;
            pad_cnt_reg   <= 2'd0;
            err_reg       <= 1'b0;
            skip_reg      <= 1'b0;
        end
        else if (load)
        begin
            acc_reg       <= acc_next;
            group_cnt_reg <= group_cnt_next;
            pad_cnt_reg   <= pad_cnt_next;
            err_reg       <= err_next;
            skip_reg      <= skip_next;
        end
    end

    // result buffer count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            num_reg <= 2'd0;
        else if (load)
            num_reg <= res_num;
        else if (out_xfer)
            num_reg <= num_reg - 2'd1;
    end

    // result buffer payload, shifts one byte per output transfer
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte0_reg  <= res_b0;
            byte1_reg  <= res_b1;
            byte2_reg  <= res_b2;
            bvalid_reg <= res_bvalid;
            status_reg <= res_status;
        end
        else if (out_xfer)
        begin
            byte0_reg <= byte1_reg;
            byte1_reg <= byte2_reg;
        end
    end

    assign out_valid  = (num_reg != 2'd0);
    assign data_byte  = byte0_reg;
    assign byte_valid = bvalid_reg;
    assign status     = status_reg;
    assign last       = (num_reg == 2'd1);

    // results that carry a byte always report ok status
    a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_valid |-> !status)
        else $error("byte result with bad status");

    // only byte results come in groups
    a_multi_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> byte_valid)
        else $error("multi-result item without bytes");

    // pad counter never passes two
    a_pad_range: assert property (@(posedge clk) disable iff (!rst_n)
        pad_cnt_reg != 2'd3)
        else $error("pad count overflow");

    // a decoded item always shows up on the output next cycle
    a_load_out: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid)
        else $error("decoded item lost");

    // an accepted input always lands in the input register
    a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> item_valid_reg)
        else $error("accepted item dropped");

endmodule
